// ===== hdl/assert_macros.svh =====
// shared assertion macros for the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hdl/rmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_pkg
// Sizes, codes and reset constants of the range minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

    // tree geometry: leaves sit at entries LEAVES .. 2*LEAVES-1
    localparam int LEAVES  = 1024;
    localparam int LEAF_W  = $clog2(LEAVES);
    localparam int NODE_W  = LEAF_W + 1;
    localparam int PTR_W   = NODE_W + 1;
    localparam int BOUND_W = LEAF_W + 1;
    localparam int DEPTH   = 2 * LEAVES;
    localparam int DATA_W  = 32;

    localparam logic [BOUND_W-1:0] LEAVES_B = BOUND_W'(LEAVES);
    localparam logic [PTR_W-1:0]   LEAVES_P = PTR_W'(LEAVES);
    localparam logic [NODE_W-1:0]  ROOT_NODE = NODE_W'(1);

    // identity after reset, also the content of every entry after reset
    localparam logic [DATA_W-1:0] IDENTITY_RESET = DATA_W'(1000000);

    // operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [DATA_W-1:0] t_data;

endpackage

`default_nettype wire

// ===== hdl/range_min_segment_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Bottom-up segment tree over LEAVES positions, minimum as the combiner.
// Update: the leaf is written, then the sibling is read and the parent written for
//   each of the 10 levels; a query walks at most 11 tree levels, then waits for a
//   free output register before it gives its word.
// Throughput: one word at a time, set by the walk per level and the output stall.
// Reset: a clearing pass writes IDENTITY_RESET to all 2048 entries, one a cycle,
//   while no word is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module range_min_segment_tree (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_wr_en,
    input  wire  [rmst_pkg::DATA_W-1:0]  i_cfg_wr_data,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_operation,
    input  wire  [rmst_pkg::LEAF_W-1:0]  i_leaf_index,
    input  wire  [rmst_pkg::DATA_W-1:0]  i_new_value,
    input  wire  [rmst_pkg::BOUND_W-1:0] i_range_left,
    input  wire  [rmst_pkg::BOUND_W-1:0] i_range_right,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [rmst_pkg::DATA_W-1:0]  o_min_value
);
    import rmst_pkg::*;

    // state codes
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_URD  = 3'd2;
    localparam logic [2:0] S_UWR  = 3'd3;
    localparam logic [2:0] S_QRUN = 3'd4;
    localparam logic [2:0] S_QOUT = 3'd5;

    // tree store and its registered read ports
    t_data r_mem [DEPTH];
    t_data r_rd_a;
    t_data r_rd_b;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    t_data             mem_wdata;
    logic [NODE_W-1:0] mem_raddr_a;
    logic [NODE_W-1:0] mem_raddr_b;

    // control and datapath registers
    logic [2:0]        r_state,    n_state;
    logic [NODE_W-1:0] r_clr,      n_clr;
    logic [NODE_W-1:0] r_node,     n_node;
    t_data             r_val,      n_val;
    logic [PTR_W-1:0]  r_lo,       n_lo;
    logic [PTR_W-1:0]  r_hi,       n_hi;
    logic              r_take_a,   n_take_a;
    logic              r_take_b,   n_take_b;
    t_data             r_acc_l,    n_acc_l;
    t_data             r_acc_r,    n_acc_r;
    t_data             r_identity, n_identity;
    logic              r_out_valid, n_out_valid;
    t_data             r_out_data, n_out_data;

    // helpers
    logic [BOUND_W-1:0] lo_sat;
    logic [BOUND_W-1:0] hi_sat;
    logic [PTR_W-1:0]   hi_dec;
    logic [NODE_W-1:0]  parent;
    t_data              upd_min;

    assign lo_sat  = (i_range_left  > LEAVES_B) ? LEAVES_B : i_range_left;
    assign hi_sat  = (i_range_right > LEAVES_B) ? LEAVES_B : i_range_right;
    assign hi_dec  = r_hi - PTR_W'(1);
    assign parent  = r_node >> 1;
    assign upd_min = (r_rd_a < r_val) ? r_rd_a : r_val;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_min_value = r_out_data;

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[mem_raddr_a];
        r_rd_b <= r_mem[mem_raddr_b];
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_take_a    = r_take_a;
        n_take_b    = r_take_b;
        n_acc_l     = r_acc_l;
        n_acc_r     = r_acc_r;
        n_identity  = r_identity;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_val;
        mem_raddr_a = r_node ^ NODE_W'(1);
        mem_raddr_b = hi_dec[NODE_W-1:0];

        if (i_cfg_wr_en) begin
            n_identity = i_cfg_wr_data;
        end

        // output word taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = IDENTITY_RESET;
                n_clr     = r_clr + NODE_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_UPDATE) begin
                        // leaf index always lies inside the tree
                        mem_we    = 1'b1;
                        mem_waddr = {1'b1, i_leaf_index};
                        mem_wdata = i_new_value;
                        n_node    = {1'b1, i_leaf_index};
                        n_val     = i_new_value;
                        n_state   = S_URD;
                    end else begin
                        n_lo     = PTR_W'(lo_sat) + LEAVES_P;
                        n_hi     = PTR_W'(hi_sat) + LEAVES_P;
                        n_acc_l  = r_identity;
                        n_acc_r  = r_identity;
                        n_take_a = 1'b0;
                        n_take_b = 1'b0;
                        n_state  = S_QRUN;
                    end
                end
            end
            S_URD: begin
                // fetch the sibling of the node on the path
                mem_raddr_a = r_node ^ NODE_W'(1);
                n_state     = S_UWR;
            end
            S_UWR: begin
                // parent gets min of path value and sibling
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = upd_min;
                n_val     = upd_min;
                n_node    = parent;
                n_state   = (parent == ROOT_NODE) ? S_IDLE : S_URD;
            end
            S_QRUN: begin
                // fold in the words read last cycle
                if (r_take_a) begin
                    n_acc_l = (r_rd_a < r_acc_l) ? r_rd_a : r_acc_l;
                end
                if (r_take_b) begin
                    n_acc_r = (r_rd_b < r_acc_r) ? r_rd_b : r_acc_r;
                end
                if (r_lo < r_hi) begin
                    mem_raddr_a = r_lo[NODE_W-1:0];
                    mem_raddr_b = hi_dec[NODE_W-1:0];
                    n_take_a    = r_lo[0];
                    n_take_b    = r_hi[0];
                    n_lo        = (r_lo + PTR_W'(r_lo[0])) >> 1;
                    n_hi        = r_hi >> 1;
                end else begin
                    n_take_a = 1'b0;
                    n_take_b = 1'b0;
                    n_state  = S_QOUT;
                end
            end
            S_QOUT: begin
                // wait for a free output register
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_acc_r < r_acc_l) ? r_acc_r : r_acc_l;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_take_a    <= 1'b0;
            r_take_b    <= 1'b0;
            r_identity  <= IDENTITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_take_a    <= n_take_a;
            r_take_b    <= n_take_b;
            r_identity  <= n_identity;
            r_out_valid <= n_out_valid;
        end
        r_node     <= n_node;
        r_val      <= n_val;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_acc_l    <= n_acc_l;
        r_acc_r    <= n_acc_r;
        r_out_data <= n_out_data;
    end

    // checks
    `RMST_ASSERT(a_query_no_write, i_clk, i_rst_n, ((r_state == S_QRUN) || (r_state == S_QOUT)) |-> !mem_we, "tree store written during a query")
    `RMST_ASSERT(a_query_bounds, i_clk, i_rst_n, ((r_state == S_QRUN) && (r_lo < r_hi)) |=> (r_lo <= r_hi), "query bounds crossed")
    `RMST_ASSERT(a_update_node, i_clk, i_rst_n, (r_state == S_URD) |-> (r_node > ROOT_NODE), "update walk past the root")
    `RMST_ASSERT(a_result_load, i_clk, i_rst_n, ((r_state == S_QOUT) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)), "finished query not delivered")

endmodule

`default_nettype wire
